// ===== hdl/separable_box_blur_stream_top_macros.svh =====
// Assertion macros for the separable box blur stream block.
// Used by separable_box_blur_stream_top; depends on nothing else.
`ifndef SEPARABLE_BOX_BLUR_STREAM_TOP_MACROS_SVH
`define SEPARABLE_BOX_BLUR_STREAM_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SBB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBB_ASSERT(lbl, prop, msg)
`define SBB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/sbb_pkg.sv =====
// Shared types, constants and tables for the separable box blur stream block.
// Used by sbb_round_div and separable_box_blur_stream_top.
`default_nettype none
package sbb_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_RADIUS = 8;
    localparam int LINE_AW    = $clog2(2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1);
    localparam int RECIP_SHIFT = 16;

    // floor(2^16 / (4r + 2)) for r = 0..MAX_RADIUS
    localparam logic [15:0] RECIP [0:MAX_RADIUS] = '{
        16'd32768, 16'd10922, 16'd6553, 16'd4681, 16'd3640,
        16'd2978,  16'd2520,  16'd2184, 16'd1927
    };

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic OP_PIXEL = 1'b0;

    typedef struct packed {
        logic       operation;
        logic [7:0] pixel_in;
    } in_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_done;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_READ,
        ST_LAST,
        ST_HDIV,
        ST_VDIV,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/sbb_round_div.sv =====
// Rounded division of a window sum by the odd window size 2r+1.
// Pipelined: reciprocal multiply, quotient estimate, then one correction step. Uses sbb_pkg.
`default_nettype none
module sbb_round_div
    import sbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [12:0] sum,
    input  wire logic [3:0]  radius,
    output logic             done,
    output logic [7:0]       quotient
);

    logic [4:0]  win;
    logic [5:0]  den;
    logic [13:0] num;
    logic [13:0] num_reg;
    logic [29:0] prod_reg;
    logic [13:0] q_est_reg;
    logic [19:0] back;
    logic [13:0] rem;
    logic        v1_reg, v2_reg, done_reg;
    logic [7:0]  q_reg;

    assign win  = {radius, 1'b1};
    assign den  = {radius, 2'b10};
    assign num  = {sum, 1'b0} + {9'd0, win};
    assign back = q_est_reg * {8'd0, den};
    assign rem  = num_reg - back[13:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            prod_reg <= num * RECIP[radius];
        end
        q_est_reg <= prod_reg[RECIP_SHIFT +: 14];
        // estimate is exact or one low: bump it when the remainder reaches the divisor
        q_reg <= q_est_reg[7:0] + {7'd0, (rem >= {8'd0, den})};
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

// ===== hdl/separable_box_blur_stream_top.sv =====
// Separable box blur over one 8-bit pixel plane, streamed in raster order.
// Depends on sbb_pkg, sbb_round_div and separable_box_blur_stream_top_macros.svh.
//
// Usage:
//   in channel  : in_valid / in_stall / in_data (operation, pixel_in). A beat is taken
//                 when in_valid is high and in_stall is low. operation 0 carries a
//                 pixel, 1 is a drain tick that counts only after the frame's last pixel.
//   out channel : out_valid / out_stall / out_data (pixel_out, frame_done). Result k
//                 comes from input beat k + r*width + r; feed r*width + r drain ticks
//                 after the last pixel. frame_done marks the frame's last result.
//   config      : cfg_wr_en / cfg_index / cfg_data. Index 0 radius, 1 frame_width,
//                 2 frame_height. A write to a listed register restarts the frame.
// Throughput: a beat that yields no result is taken without raising in_stall. A beat
//   that yields a result holds in_stall while each of the 2r+1 rows reads 2r+1 pixels
//   from the line memory one per cycle and goes through the rounded divider, then the
//   vertical divide runs and the result waits for the output register to be free.
// Reset: radius 1, 1920 x 1080, counters cleared; the line memory is not cleared,
//   every entry read was written earlier in the same frame.
// Stall: a finished result waits in the output register; the block still takes the
//   next beat, and holds its next result until the register drains.
`default_nettype none
`include "separable_box_blur_stream_top_macros.svh"
module separable_box_blur_stream_top
    import sbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    // configuration
    logic [3:0]  radius_reg;
    logic [11:0] width_reg, height_reg;
    logic [3:0]  r_eff;
    logic [11:0] w_eff, h_eff;
    logic [10:0] wm1, hm1;
    logic [22:0] frame_total;
    logic [14:0] frame_lag;
    logic [4:0]  two_r;

    // sequencer state
    state_t      state_reg, state_next;
    logic [22:0] items_reg, items_next;
    logic [21:0] results_reg, results_next;
    logic [10:0] x_reg, x_next, y_reg, y_next;
    logic [4:0]  i_reg, i_next, j_reg, j_next;
    logic [21:0] row_base_reg, row_base_next;
    logic [12:0] hsum_reg, hsum_next, vsum_reg, vsum_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [7:0]  blur_reg, blur_next;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg, out_next;

    // line memory
    logic [7:0]         line_mem [0:(1 << LINE_AW) - 1];
    logic [7:0]         mem_q_reg;
    logic               wr_en;
    logic [LINE_AW-1:0] rd_addr;
    logic [21:0]        rd_pos;

    // window addressing
    logic signed [12:0] ty, tx;
    logic [10:0]        row, col;
    logic [22:0]        row_prod;

    logic        accept;
    logic        div_start, div_done;
    logic [12:0] div_sum;
    logic [7:0]  div_q;
    logic        last_result;

    assign r_eff = (radius_reg > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_reg;
    assign w_eff = (width_reg == 12'd0) ? 12'd1 :
                   ((width_reg > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_reg);
    assign h_eff = (height_reg == 12'd0) ? 12'd1 :
                   ((height_reg > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : height_reg);
    assign wm1   = 11'(w_eff - 12'd1);
    assign hm1   = 11'(h_eff - 12'd1);
    assign two_r = {r_eff, 1'b0};

    // frame size and latency follow the live settings
    assign frame_total = {11'd0, w_eff} * {11'd0, h_eff};
    assign frame_lag   = ({11'd0, r_eff} * {3'd0, w_eff}) + {11'd0, r_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 4'd1;
            width_reg  <= 12'd1920;
            height_reg <= 12'd1080;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_RADIUS: radius_reg <= cfg_data[3:0];
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // clamp the window tap to the frame edges
    assign ty  = $signed({2'b00, y_reg}) + $signed({8'd0, i_reg}) - $signed({9'd0, r_eff});
    assign tx  = $signed({2'b00, x_reg}) + $signed({8'd0, j_reg}) - $signed({9'd0, r_eff});
    assign row = (ty < 0) ? 11'd0 : ((ty > $signed({2'b00, hm1})) ? hm1 : ty[10:0]);
    assign col = (tx < 0) ? 11'd0 : ((tx > $signed({2'b00, wm1})) ? wm1 : tx[10:0]);
    assign row_prod = row * w_eff;
    assign rd_pos   = row_base_reg + {11'd0, col};
    assign rd_addr  = rd_pos[LINE_AW-1:0];

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign wr_en    = accept && (items_reg < frame_total) && (in_data.operation == OP_PIXEL);
    assign last_result = ({1'b0, results_reg} + 23'd1) >= frame_total;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[items_reg[LINE_AW-1:0]] <= in_data.pixel_in;
        end
        mem_q_reg <= line_mem[rd_addr];
    end

    sbb_round_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (div_sum),
        .radius   (r_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        items_next     = items_reg;
        results_next   = results_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        row_base_next  = row_base_reg;
        hsum_next      = hsum_reg;
        vsum_next      = vsum_reg;
        rd_pend_next   = rd_pend_reg;
        blur_next      = blur_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        div_sum        = hsum_reg + {5'd0, mem_q_reg};

        // drain the output register
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // drop early drain ticks: they change nothing
                if (accept && !((items_reg < frame_total) &&
                                (in_data.operation != OP_PIXEL)))
                begin
                    items_next = items_reg + 23'd1;
                    if (items_reg >= {8'd0, frame_lag})
                    begin
                        i_next     = 5'd0;
                        vsum_next  = 13'd0;
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                row_base_next = row_prod[21:0];
                j_next        = 5'd0;
                hsum_next     = 13'd0;
                rd_pend_next  = 1'b0;
                state_next    = ST_READ;
            end
            ST_READ:
            begin
                // issue one tap read and accumulate the previous one
                if (rd_pend_reg)
                begin
                    hsum_next = hsum_reg + {5'd0, mem_q_reg};
                end
                rd_pend_next = 1'b1;
                if (j_reg == two_r)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    j_next = j_reg + 5'd1;
                end
            end
            ST_LAST:
            begin
                div_start  = 1'b1;
                state_next = ST_HDIV;
            end
            ST_HDIV:
            begin
                if (div_done)
                begin
                    if (i_reg == two_r)
                    begin
                        div_start  = 1'b1;
                        div_sum    = vsum_reg + {5'd0, div_q};
                        state_next = ST_VDIV;
                    end
                    else
                    begin
                        vsum_next  = vsum_reg + {5'd0, div_q};
                        i_next     = i_reg + 5'd1;
                        state_next = ST_ROW;
                    end
                end
            end
            ST_VDIV:
            begin
                if (div_done)
                begin
                    blur_next  = div_q;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    out_next.pixel_out  = blur_reg;
                    out_next.frame_done = last_result;
                    state_next          = ST_IDLE;
                    if (last_result)
                    begin
                        items_next   = 23'd0;
                        results_next = 22'd0;
                        x_next       = 11'd0;
                        y_next       = 11'd0;
                    end
                    else
                    begin
                        results_next = results_reg + 22'd1;
                        if (x_reg == wm1)
                        begin
                            x_next = 11'd0;
                            y_next = y_reg + 11'd1;
                        end
                        else
                        begin
                            x_next = x_reg + 11'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a write to a listed register restarts the frame
        if (cfg_wr_en && (cfg_index == CFG_RADIUS || cfg_index == CFG_WIDTH ||
                          cfg_index == CFG_HEIGHT))
        begin
            items_next   = 23'd0;
            results_next = 22'd0;
            x_next       = 11'd0;
            y_next       = 11'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            items_reg     <= 23'd0;
            results_reg   <= 22'd0;
            x_reg         <= 11'd0;
            y_reg         <= 11'd0;
            i_reg         <= 5'd0;
            j_reg         <= 5'd0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            items_reg     <= items_next;
            results_reg   <= results_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_base_reg <= row_base_next;
        hsum_reg     <= hsum_next;
        vsum_reg     <= vsum_next;
        blur_reg     <= blur_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SBB_ASSERT(a_tap_in_window, (state_reg == ST_READ) |-> (j_reg <= two_r), "tap index past window")
    `SBB_ASSERT(a_div_owner, div_done |-> (state_reg == ST_HDIV || state_reg == ST_VDIV), "divider result with no consumer")
    `SBB_ASSERT(a_frame_restart, (out_valid && !out_stall && out_data.frame_done && state_reg == ST_IDLE && !accept) |=> (items_reg == 23'd0 || $past(cfg_wr_en)), "frame counter not cleared")
    `SBB_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (state_reg == ST_IDLE && !out_valid_reg), "not idle in reset")

endmodule
`default_nettype wire

// ===== test/separable_box_blur_stream_top_tb.sv =====
// Self-checking testbench for separable_box_blur_stream_top: random small frames,
// edge sizes and noisy drain sequences, checked against an in-bench blur predictor.
// Depends on sbb_pkg and the block's RTL only.
`timescale 1ns / 100ps
module separable_box_blur_stream_top_tb
    import sbb_pkg::*;
();

    localparam int LINE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam logic [1:0] CFG_SPARE = 2'd3;    // index past the register list
    localparam logic OP_DRAIN = 1'b1;
    localparam int SETTLE_CYCLES = 450;         // worst result time at radius 8, with margin
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_BUDGET = 1350;
    localparam int QUIET_ITEMS = 250;           // tail of the run with no idling
    localparam int EDGE_PIXELS = 200;           // leading pixels of the widest and tallest frames

    // Blur predictor plus the queue of results still owed by the block.
    class blur_scoreboard;
        bit [7:0] line_mem [LINE_DEPTH];
        int unsigned pixels_seen;
        int unsigned results_owed;
        int unsigned radius_reg;
        int unsigned width_reg;
        int unsigned height_reg;
        out_t blurred_q [$];
        int unsigned failures;
        int unsigned mismatches;

        function new();
            pixels_seen = 0;
            results_owed = 0;
            radius_reg = 1;
            width_reg = 1920;
            height_reg = 1080;
            failures = 0;
            mismatches = 0;
        endfunction

        function int unsigned eff_radius();
            return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0)
                return 1;
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        endfunction

        function void write_reg(logic [1:0] idx, logic [11:0] val);
            case (idx)
                CFG_RADIUS: radius_reg = val[3:0];
                CFG_WIDTH:  width_reg = val;
                CFG_HEIGHT: height_reg = val;
                default:    return;
            endcase
            pixels_seen = 0;
            results_owed = 0;
        endfunction

        function int unsigned rounded_mean(int unsigned sum, int unsigned d);
            return (2 * sum + d) / (2 * d);
        endfunction

        function int clamp(int v, int hi);
            if (v < 0)
                return 0;
            return (v > hi) ? hi : v;
        endfunction

        // Two-stage box mean at raster position pos, edges clamped.
        function bit [7:0] box_mean(int unsigned pos, int unsigned r, int unsigned w,
                                    int unsigned h);
            int y;
            int x;
            int unsigned d;
            int unsigned col_acc;
            int unsigned row_acc;
            int unsigned row;
            int unsigned col;
            y = pos / w;
            x = pos % w;
            d = 2 * r + 1;
            col_acc = 0;
            for (int dy = -int'(r); dy <= int'(r); dy++)
            begin
                row = clamp(y + dy, h - 1);
                row_acc = 0;
                for (int dx = -int'(r); dx <= int'(r); dx++)
                begin
                    col = clamp(x + dx, w - 1);
                    row_acc += line_mem[(row * w + col) % LINE_DEPTH];
                end
                col_acc += rounded_mean(row_acc, d);
            end
            return rounded_mean(col_acc, d);
        endfunction

        function void note_input(in_t beat);
            int unsigned r;
            int unsigned w;
            int unsigned h;
            int unsigned k;
            out_t res;
            r = eff_radius();
            w = eff_width();
            h = eff_height();
            if (pixels_seen < w * h)
            begin
                if (beat.operation != OP_PIXEL)
                    return;     // early drain tick: ignored
                line_mem[pixels_seen % LINE_DEPTH] = beat.pixel_in;
            end
            k = pixels_seen;
            pixels_seen++;
            if (k < r * w + r)
                return;
            res.pixel_out = box_mean(results_owed, r, w, h);
            results_owed++;
            res.frame_done = (results_owed >= w * h);
            if (res.frame_done)
            begin
                pixels_seen = 0;
                results_owed = 0;
            end
            blurred_q.push_back(res);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (blurred_q.size() == 0)
            begin
                failures++;
                if (mismatches++ < 10)
                    $display("unexpected result: pixel_out %0d frame_done %0d",
                             got.pixel_out, got.frame_done);
                return;
            end
            want = blurred_q.pop_front();
            if (got !== want)
            begin
                failures++;
                if (mismatches++ < 10)
                    $display("mismatch: pixel_out exp %0d got %0d, frame_done exp %0d got %0d",
                             want.pixel_out, got.pixel_out, want.frame_done, got.frame_done);
            end
        endfunction

        function int pending();
            return blurred_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    blur_scoreboard sb;
    bit quiet;              // no idling on either side
    int unsigned beats_sent;
    int unsigned stall_left;
    int unsigned idle_cycles;

    separable_box_blur_stream_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Check every result beat as it leaves the block.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Back-pressure the result side in random bursts; drop it once quiet.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if (!quiet && rst_n && $urandom_range(0, 9) == 0)
        begin
            out_stall = 1'b1;
            stall_left = $urandom_range(1, 6) - 1;
        end
        else
            out_stall = 1'b0;
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive one beat; hold it until taken. Entered and left at a falling edge.
    task automatic send_beat(logic op, logic [7:0] pix);
        in_t beat;
        beat.operation = op;
        beat.pixel_in = pix;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = beat;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(beat);
        beats_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        sb.write_reg(idx, val);
        cfg_wr_en = 1'b0;
    endtask

    task automatic configure(logic [11:0] r, logic [11:0] w, logic [11:0] h);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // Wait until every owed result is out, then let a result in progress finish.
    task automatic settle();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] any_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // One frame with the current registers. Optionally truncate it, sprinkle
    // early drain ticks and extra pixels, or pause for the results mid-frame.
    task automatic run_frame(bit truncate, bit noisy, bit pause_mid);
        int unsigned total;
        int unsigned lag;
        int unsigned n_pix;
        total = sb.eff_width() * sb.eff_height();
        lag = sb.eff_radius() * sb.eff_width() + sb.eff_radius();
        n_pix = truncate ? $urandom_range(0, total - 1) : total;
        for (int unsigned i = 0; i < n_pix; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_beat(OP_DRAIN, $urandom_range(0, 255));
            if (pause_mid && i == n_pix / 2)
                while (sb.pending() != 0)
                    @(negedge clk);
            send_beat(OP_PIXEL, any_pixel());
        end
        if (!truncate)
            for (int unsigned j = 0; j < lag; j++)
                send_beat((noisy && $urandom_range(0, 2) == 0) ? OP_PIXEL : OP_DRAIN,
                          $urandom_range(0, 255));
        settle();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        quiet = 1'b0;
        beats_sent = 0;
        stall_left = 0;
        idle_cycles = 0;
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: 3x2 frame by hand with an early drain and an extra pixel.
        configure(12'd1, 12'd3, 12'd2);
        send_beat(OP_PIXEL, 8'd0);
        send_beat(OP_PIXEL, 8'd255);
        send_beat(OP_DRAIN, 8'd77);
        send_beat(OP_PIXEL, 8'd255);
        send_beat(OP_PIXEL, 8'd0);
        send_beat(OP_PIXEL, 8'd255);
        send_beat(OP_PIXEL, 8'd128);
        send_beat(OP_DRAIN, 8'd0);
        send_beat(OP_PIXEL, 8'd99);
        send_beat(OP_DRAIN, 8'd0);
        send_beat(OP_DRAIN, 8'd0);
        settle();
        // Single pixel at radius 0, then a write past the register list.
        configure(12'd0, 12'd1, 12'd1);
        send_beat(OP_PIXEL, 8'd255);
        settle();
        write_reg(CFG_SPARE, 12'hFFF);
        send_beat(OP_PIXEL, 8'd1);
        settle();
        // Zero sizes act as one; an oversized radius acts as the maximum.
        configure(12'd15, 12'd0, 12'd0);
        send_beat(OP_PIXEL, 8'd200);
        for (int i = 0; i < 8; i++)
            send_beat(OP_DRAIN, 8'd0);
        settle();

        // Widest row and tallest column (oversized height saturates); feed the
        // leading pixels only, the next write restarts the frame.
        configure(12'd0, 12'd2048, 12'd1);
        for (int i = 0; i < EDGE_PIXELS; i++)
            send_beat(OP_PIXEL, any_pixel());
        settle();
        configure(12'd0, 12'd1, 12'd4095);
        for (int i = 0; i < EDGE_PIXELS; i++)
            send_beat(OP_PIXEL, any_pixel());
        settle();
        configure(12'd8, 12'd17, 12'd17);
        run_frame(1'b0, 1'b1, 1'b1);

        // Random frames, mostly small radii; the tail runs with no idling.
        while (beats_sent < ITEM_BUDGET)
        begin
            if (beats_sent >= ITEM_BUDGET - QUIET_ITEMS)
                quiet = 1'b1;
            configure(($urandom_range(0, 9) == 0) ? $urandom_range(4, 15)
                                                  : $urandom_range(0, 3),
                      $urandom_range(0, 16), $urandom_range(0, 10));
            run_frame($urandom_range(0, 7) == 0, $urandom_range(0, 2) == 0,
                      $urandom_range(0, 15) == 0);
        end

        settle();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== separable_box_blur_stream_top.f =====
+incdir+hdl
hdl/sbb_pkg.sv
hdl/sbb_round_div.sv
hdl/separable_box_blur_stream_top.sv
test/separable_box_blur_stream_top_tb.sv
